>>> rtl/tfi_pkg.sv
// tfi_pkg: shared constants, codes, types and helpers for the table factor interpolator
// no dependencies; used by every rtl file of the block
`default_nettype none

package tfi_pkg;

    localparam int TABLE_DEPTH_DEF = 128;

    // item modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // table codes
    localparam logic [1:0] TAB_SMALL_CAP = 2'd0;
    localparam logic [1:0] TAB_LARGE_CAP = 2'd1;
    localparam logic [1:0] TAB_INDUCTOR  = 2'd2;
    localparam logic [1:0] TAB_NONE      = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_SMALL_CAP_ENTRIES = 2'd0;
    localparam logic [1:0] REG_LARGE_CAP_ENTRIES = 2'd1;
    localparam logic [1:0] REG_INDUCTOR_ENTRIES  = 2'd2;

    localparam logic [7:0] ENTRIES_RESET = 8'd2;

    // table origins and steps
    localparam logic [15:0] START_SMALL_CAP = 16'd1000;
    localparam logic [15:0] START_LARGE_CAP = 16'd300;
    localparam logic [15:0] START_INDUCTOR  = 16'd200;
    localparam logic [5:0]  STEP_NARROW     = 6'd25;
    localparam logic [5:0]  STEP_WIDE       = 6'd50;
    localparam logic [15:0] HALF_NARROW     = 16'd12;
    localparam logic [15:0] HALF_WIDE       = 16'd25;

    // reciprocal for exact division of a 16-bit value:
    // ceil(2^21 / 25) = ceil(2^22 / 50) = 83887
    localparam logic [16:0] RECIP_M      = 17'd83887;
    localparam int          PROD_W       = 33;
    localparam int          SHIFT_NARROW = 21;
    localparam int          SHIFT_WIDE   = 22;
    localparam int          QUOT_W       = PROD_W - SHIFT_NARROW;

    typedef struct packed {
        logic [7:0] small_cap;
        logic [7:0] large_cap;
        logic [7:0] inductor;
    } entries_t;

    // lookup control travelling alongside the table words
    typedef struct packed {
        logic       valid;
        logic       bad;
        logic       wide;
        logic [5:0] weight;
    } lk_ctrl_t;

    function automatic logic [15:0] start_of(input logic [1:0] choice);
        logic [15:0] s;
        case (choice)
            TAB_SMALL_CAP: s = START_SMALL_CAP;
            TAB_LARGE_CAP: s = START_LARGE_CAP;
            TAB_INDUCTOR:  s = START_INDUCTOR;
            default:       s = 16'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/tfi_index.sv
// tfi_index: front stages - offset, division by the step via reciprocal, index clamp, addressing
// depends on tfi_pkg
`default_nettype none

module tfi_index #(
    parameter int TABLE_DEPTH = tfi_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  accept,
    input  wire logic                                  mode,
    input  wire logic [1:0]                            table_choice,
    input  wire logic [6:0]                            entry_index,
    input  wire logic [15:0]                           entry_value,
    input  wire logic [15:0]                           level,
    input  wire tfi_pkg::entries_t                     entries,
    output logic                                       wr_en,
    output logic [$clog2(3*TABLE_DEPTH)-1:0]           wr_addr,
    output logic [15:0]                                wr_data,
    output logic [$clog2(3*TABLE_DEPTH)-1:0]           rd_addr_a,
    output logic [$clog2(3*TABLE_DEPTH)-1:0]           rd_addr_b,
    output tfi_pkg::lk_ctrl_t                          ctrl
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int ADDR_W = $clog2(3*TABLE_DEPTH);

    logic                       valid_reg;
    logic                       mode_reg;
    logic [1:0]                 choice_reg;
    logic [6:0]                 eidx_reg;
    logic [15:0]                evalue_reg;
    logic [15:0]                diff_reg;
    logic [tfi_pkg::PROD_W-1:0] prod_reg;

    logic [15:0]                start_val;
    logic [15:0]                diff_next;
    logic [tfi_pkg::PROD_W-1:0] prod_next;

    logic [tfi_pkg::QUOT_W-1:0] q25;
    logic [4:0]                 rem25;
    logic                       wide;
    logic [tfi_pkg::QUOT_W-1:0] quot;
    logic [5:0]                 rem;
    logic [5:0]                 step;
    logic [7:0]                 ent_sel;
    logic [8:0]                 ent_lim;
    logic [8:0]                 ent_max;
    logic [tfi_pkg::QUOT_W-1:0] idx_full;
    logic [IDX_W-1:0]           idx;
    logic [ADDR_W-1:0]          base;

    // offset and reciprocal product, registered
    always_comb
    begin
        start_val = tfi_pkg::start_of(table_choice);
        diff_next = (level >= start_val) ? (level - start_val) : 16'd0;
        prod_next = {17'b0, diff_next} * {16'b0, tfi_pkg::RECIP_M};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode;
            choice_reg <= table_choice;
            eidx_reg   <= entry_index;
            evalue_reg <= entry_value;
            diff_reg   <= diff_next;
            prod_reg   <= prod_next;
        end
    end

    // quotient, remainder and weight
    always_comb
    begin
        q25   = prod_reg[tfi_pkg::PROD_W-1:tfi_pkg::SHIFT_NARROW];
        rem25 = 5'(diff_reg - 16'(q25 * 16'(tfi_pkg::STEP_NARROW)));
        wide  = (choice_reg == tfi_pkg::TAB_SMALL_CAP);
        if (wide)
        begin
            quot = {1'b0, q25[tfi_pkg::QUOT_W-1:1]};
            rem  = 6'(rem25) + (q25[0] ? tfi_pkg::STEP_NARROW : 6'd0);
            step = tfi_pkg::STEP_WIDE;
        end
        else
        begin
            quot = q25;
            rem  = 6'(rem25);
            step = tfi_pkg::STEP_NARROW;
        end
    end

    // entry count limit and index clamp
    always_comb
    begin
        case (choice_reg)
            tfi_pkg::TAB_SMALL_CAP: ent_sel = entries.small_cap;
            tfi_pkg::TAB_LARGE_CAP: ent_sel = entries.large_cap;
            default:                ent_sel = entries.inductor;
        endcase
        if ({1'b0, ent_sel} < 9'd2)
        begin
            ent_lim = 9'd2;
        end
        else if ({1'b0, ent_sel} > 9'(TABLE_DEPTH))
        begin
            ent_lim = 9'(TABLE_DEPTH);
        end
        else
        begin
            ent_lim = {1'b0, ent_sel};
        end
        ent_max  = ent_lim - 9'd2;
        idx_full = (quot > tfi_pkg::QUOT_W'(ent_max)) ? tfi_pkg::QUOT_W'(ent_max) : quot;
        idx      = IDX_W'(idx_full);
    end

    always_comb
    begin
        case (choice_reg)
            tfi_pkg::TAB_SMALL_CAP: base = ADDR_W'(0);
            tfi_pkg::TAB_LARGE_CAP: base = ADDR_W'(TABLE_DEPTH);
            default:                base = ADDR_W'(2*TABLE_DEPTH);
        endcase
    end

    assign rd_addr_a = base + ADDR_W'(idx);
    assign rd_addr_b = rd_addr_a + ADDR_W'(1);

    // loads write in item order, one stage ahead of any later lookup's read
    assign wr_en   = valid_reg && (mode_reg == tfi_pkg::MODE_LOAD)
                     && (choice_reg != tfi_pkg::TAB_NONE)
                     && ({2'b0, eidx_reg} < 9'(TABLE_DEPTH));
    assign wr_addr = base + ADDR_W'(eidx_reg);
    assign wr_data = evalue_reg;

    assign ctrl.valid  = valid_reg && (mode_reg == tfi_pkg::MODE_LOOKUP);
    assign ctrl.bad    = (choice_reg == tfi_pkg::TAB_NONE);
    assign ctrl.wide   = wide;
    assign ctrl.weight = step - rem;

endmodule

`default_nettype wire

>>> rtl/tfi_store.sv
// tfi_store: factor memory of the three tables, one write port, two registered read ports
// depends on tfi_pkg
`default_nettype none

module tfi_store #(
    parameter int TABLE_DEPTH = tfi_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  wr_en,
    input  wire logic [$clog2(3*TABLE_DEPTH)-1:0]      wr_addr,
    input  wire logic [15:0]                           wr_data,
    input  wire logic [$clog2(3*TABLE_DEPTH)-1:0]      rd_addr_a,
    input  wire logic [$clog2(3*TABLE_DEPTH)-1:0]      rd_addr_b,
    input  wire tfi_pkg::lk_ctrl_t                     ctrl_in,
    output logic [15:0]                                rd_data_a,
    output logic [15:0]                                rd_data_b,
    output tfi_pkg::lk_ctrl_t                          ctrl_out
);

    logic [15:0]       mem [0:3*TABLE_DEPTH-1];
    logic [15:0]       rd_a_reg;
    logic [15:0]       rd_b_reg;
    tfi_pkg::lk_ctrl_t ctrl_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl_in.valid)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;
    assign ctrl_out  = ctrl_reg;

endmodule

`default_nettype wire

>>> rtl/tfi_blend.sv
// tfi_blend: back stages - weighted difference, rounding, division by the step, output register
// depends on tfi_pkg
`default_nettype none

module tfi_blend (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [15:0]       word_a,
    input  wire logic [15:0]       word_b,
    input  wire tfi_pkg::lk_ctrl_t ctrl,
    output logic                   done,
    output logic [15:0]            factor,
    output logic                   bad_table
);

    logic [15:0]                sum_reg;
    logic [15:0]                b3_reg;
    tfi_pkg::lk_ctrl_t          ctrl3_reg;
    logic [tfi_pkg::PROD_W-1:0] prod_reg;
    logic [15:0]                b4_reg;
    tfi_pkg::lk_ctrl_t          ctrl4_reg;
    logic [15:0]                factor_reg;
    logic                       bad_reg;
    logic                       done_reg;

    logic [15:0]                delta;
    logic [21:0]                mul_full;
    logic [15:0]                sum_next;
    logic [15:0]                quot;
    logic [15:0]                factor_next;

    // (a - b) * w + step / 2, wrapped to 16 bits
    always_comb
    begin
        delta    = word_a - word_b;
        mul_full = 22'(delta) * 22'(ctrl.weight);
        sum_next = mul_full[15:0]
                   + (ctrl.wide ? tfi_pkg::HALF_WIDE : tfi_pkg::HALF_NARROW);
    end

    // quotient by the step, plus b
    always_comb
    begin
        if (ctrl4_reg.wide)
        begin
            quot = 16'(prod_reg[tfi_pkg::PROD_W-1:tfi_pkg::SHIFT_WIDE]);
        end
        else
        begin
            quot = 16'(prod_reg[tfi_pkg::PROD_W-1:tfi_pkg::SHIFT_NARROW]);
        end
        factor_next = ctrl4_reg.bad ? 16'd0 : (quot + b4_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl3_reg <= '0;
            ctrl4_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            ctrl3_reg <= ctrl;
            ctrl4_reg <= ctrl3_reg;
            done_reg  <= ctrl4_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        b3_reg     <= word_b;
        prod_reg   <= {17'b0, sum_reg} * {16'b0, tfi_pkg::RECIP_M};
        b4_reg     <= b3_reg;
        factor_reg <= factor_next;
        bad_reg    <= ctrl4_reg.bad;
    end

    assign done      = done_reg;
    assign factor    = factor_reg;
    assign bad_table = bad_reg;

endmodule

`default_nettype wire

>>> rtl/table_factor_interpolator_top.sv
// table_factor_interpolator_top: top level, configuration registers and pipeline wiring
// depends on tfi_pkg, tfi_index, tfi_store, tfi_blend
`default_nettype none

// usage
// - item channel: an item is taken at a rising edge with start high and busy low;
//   mode selects a table load (no result) or a lookup (one result)
// - busy is high only during reset and until the first clock edge after it;
//   from then on an item may be taken on every cycle, loads and lookups freely mixed
// - result channel: done marks factor and bad_table for exactly one cycle; a lookup
//   reaches the result channel through five register stages: offset and
//   reciprocal product, table read, weighted difference, quotient product and
//   output register
// - throughput is one item per cycle, set by stages that never stall and the
//   two read ports of the factor memory
// - a load reaches the memory one stage ahead of the read of any later lookup,
//   so a lookup directly after a load already sees the new entry
// - the receiver cannot stall: every result is a transfer in its own cycle
// - configuration: cfg_ready is always high; a transfer with cfg_index 0, 1 or 2
//   writes the entry count of the small cap, large cap or inductor table, any
//   other index is ignored; write only while no lookup is in flight
// - reset clears the pipeline valid bits and sets all entry counts to 2; the
//   table memory is not cleared and entries must be loaded before use
module table_factor_interpolator_top #(
    parameter int TABLE_DEPTH = tfi_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic        mode,
    input  wire logic [1:0]  table_choice,
    input  wire logic [6:0]  entry_index,
    input  wire logic [15:0] entry_value,
    input  wire logic [15:0] level,
    // result channel
    output logic             done,
    output logic [15:0]      factor,
    output logic             bad_table,
    // configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int ADDR_W = $clog2(3*TABLE_DEPTH);

    logic              busy_reg;
    tfi_pkg::entries_t entries_reg;
    tfi_pkg::entries_t entries_next;

    logic              accept;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    tfi_pkg::lk_ctrl_t idx_ctrl;
    tfi_pkg::lk_ctrl_t rd_ctrl;
    logic [15:0]       word_a;
    logic [15:0]       word_b;

    // busy only covers the reset window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy      = busy_reg;
    assign accept    = start && !busy_reg;
    assign cfg_ready = 1'b1;

    // entry count registers
    always_comb
    begin
        entries_next = entries_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tfi_pkg::REG_SMALL_CAP_ENTRIES: entries_next.small_cap = cfg_data;
                tfi_pkg::REG_LARGE_CAP_ENTRIES: entries_next.large_cap = cfg_data;
                tfi_pkg::REG_INDUCTOR_ENTRIES:  entries_next.inductor  = cfg_data;
                default:                        entries_next = entries_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg.small_cap <= tfi_pkg::ENTRIES_RESET;
            entries_reg.large_cap <= tfi_pkg::ENTRIES_RESET;
            entries_reg.inductor  <= tfi_pkg::ENTRIES_RESET;
        end
        else
        begin
            entries_reg <= entries_next;
        end
    end

    // front: offset, step division, clamp and addressing
    tfi_index #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_index (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .mode         (mode),
        .table_choice (table_choice),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .level        (level),
        .entries      (entries_reg),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_addr_a    (rd_addr_a),
        .rd_addr_b    (rd_addr_b),
        .ctrl         (idx_ctrl)
    );

    // factor memory, both neighbouring entries read in the same cycle
    tfi_store #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .ctrl_in   (idx_ctrl),
        .rd_data_a (word_a),
        .rd_data_b (word_b),
        .ctrl_out  (rd_ctrl)
    );

    // back: rounding interpolation and output register
    tfi_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .word_a    (word_a),
        .word_b    (word_b),
        .ctrl      (rd_ctrl),
        .done      (done),
        .factor    (factor),
        .bad_table (bad_table)
    );

`ifndef SYNTHESIS
    a_lookup_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == tfi_pkg::MODE_LOOKUP) |-> ##5 done
    ) else $error("accepted lookup produced no result transfer");

    a_result_has_lookup: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && mode == tfi_pkg::MODE_LOOKUP, 5)
    ) else $error("result transfer without a matching lookup");

    a_bad_table_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && bad_table) |->
            (factor == 16'd0 && $past(table_choice, 5) == tfi_pkg::TAB_NONE)
    ) else $error("bad table result not zero or not from an invalid table");
`endif

endmodule

`default_nettype wire

>>> verif/tb_table_factor_interpolator_top.sv
// testbench for table_factor_interpolator_top: loads the three factor tables, runs lookups
// through random idle gaps and several entry-count settings, checks every result in order
// depends on tfi_pkg and the rtl of the block
`timescale 1ns / 100ps

module tb_table_factor_interpolator_top;

    // config index that names no register, the block must ignore it
    localparam logic [1:0] REG_NONE = 2'd3;

    // one item waiting to be driven, with the idle cycles that precede it
    typedef struct {
        logic        mode;
        logic [1:0]  choice;
        logic [6:0]  slot;
        logic [15:0] value;
        logic [15:0] lvl;
        int unsigned idle_before;
        bit          hold;
    } tfi_item_t;

    typedef struct {
        logic [15:0] factor;
        logic        bad;
    } tfi_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        mode = tfi_pkg::MODE_LOAD;
    logic [1:0]  table_choice = tfi_pkg::TAB_SMALL_CAP;
    logic [6:0]  entry_index = 7'd0;
    logic [15:0] entry_value = 16'd0;
    logic [15:0] level = 16'd0;
    logic        done;
    logic [15:0] factor;
    logic        bad_table;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = tfi_pkg::REG_SMALL_CAP_ENTRIES;
    logic [7:0]  cfg_data = 8'd0;

    // predictor state: the table words and the entry count registers
    logic [15:0] factor_words [3][128];
    logic [7:0]  entry_count [3];

    tfi_item_t   pending_items [$];
    tfi_result_t factor_due [$];
    tfi_item_t   next_item;
    bit          in_flight = 1'b0;
    bit          took_item = 1'b0;
    int unsigned idle_count = 0;
    int unsigned fail_count = 0;

    table_factor_interpolator_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .table_choice (table_choice),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .level        (level),
        .done         (done),
        .factor       (factor),
        .bad_table    (bad_table),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // level at which the first entry of a table applies
    function automatic logic [15:0] origin_of(input logic [1:0] tab);
        case (tab)
            tfi_pkg::TAB_SMALL_CAP: return 16'd1000;
            tfi_pkg::TAB_LARGE_CAP: return 16'd300;
            tfi_pkg::TAB_INDUCTOR:  return 16'd200;
            default:                return 16'd0;
        endcase
    endfunction

    // level distance between neighbouring entries
    function automatic logic [5:0] pitch_of(input logic [1:0] tab);
        return (tab == tfi_pkg::TAB_SMALL_CAP) ? 6'd50 : 6'd25;
    endfunction

    // entry count as the block uses it: below two acts as two, above depth as depth
    function automatic logic [8:0] usable_entries(input logic [1:0] tab);
        logic [8:0] n;
        n = (tab == tfi_pkg::TAB_NONE) ? 9'd2 : {1'b0, entry_count[tab]};
        if (n < 9'd2)
            n = 9'd2;
        else if (n > tfi_pkg::TABLE_DEPTH_DEF)
            n = 9'(tfi_pkg::TABLE_DEPTH_DEF);
        return n;
    endfunction

    // interpolated factor, every step wrapping at 16 bits
    function automatic logic [15:0] blend_factor(input logic [1:0] tab, input logic [15:0] lvl);
        logic [15:0] origin;
        logic [15:0] span;
        logic [15:0] slot;
        logic [15:0] wgt;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] acc;
        logic [5:0]  pitch;
        logic [8:0]  last;
        origin = origin_of(tab);
        pitch  = pitch_of(tab);
        span   = (lvl >= origin) ? lvl - origin : 16'd0;
        slot   = span / pitch;
        // weight comes from the remainder before the index is clamped
        wgt    = pitch - (span % pitch);
        last   = usable_entries(tab) - 9'd2;
        if (slot > last)
            slot = 16'(last);
        lo  = factor_words[tab][slot];
        hi  = factor_words[tab][slot + 1];
        acc = lo - hi;
        acc = acc * wgt;
        acc = acc + pitch / 2;
        acc = acc / pitch;
        return acc + hi;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly back to back or short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_item(input logic m, input logic [1:0] tab, input logic [6:0] slot,
                              input logic [15:0] value, input logic [15:0] lvl,
                              input int unsigned idle);
        tfi_item_t it;
        it.mode        = m;
        it.choice      = tab;
        it.slot        = slot;
        it.value       = value;
        it.lvl         = lvl;
        it.idle_before = idle;
        it.hold        = 1'b0;
        pending_items.push_back(it);
    endtask

    // random mix of loads and lookups, levels mostly inside the populated span
    task automatic queue_random(input int num, input int hold_at);
        tfi_item_t   it;
        bit          quiet;
        int unsigned r;
        int unsigned origin;
        int unsigned pitch;
        int unsigned used;
        quiet = 1'b0;
        for (int k = 0; k < num; k++)
        begin
            // stretches of back-to-back transfers
            if (k % 64 == 0)
                quiet = ($urandom_range(0, 9) < 3);
            it.mode   = ($urandom_range(0, 9) < 3) ? tfi_pkg::MODE_LOAD : tfi_pkg::MODE_LOOKUP;
            it.choice = ($urandom_range(0, 19) == 0) ? tfi_pkg::TAB_NONE
                                                      : 2'($urandom_range(0, 2));
            it.slot   = 7'($urandom);
            r = $urandom_range(0, 9);
            if (r == 0)
                it.value = 16'd0;
            else if (r == 1)
                it.value = 16'hffff;
            else
                it.value = 16'($urandom);
            origin = origin_of(it.choice);
            pitch  = pitch_of(it.choice);
            used   = usable_entries(it.choice);
            r = $urandom_range(0, 9);
            if (r < 6)
                it.lvl = 16'(origin - pitch + $urandom_range(0, pitch * (used + 1)));
            else if (r < 7)
                // on a grid point or just below the next one
                it.lvl = 16'(origin + pitch * $urandom_range(0, used - 1)
                             + ($urandom_range(0, 1) ? 0 : pitch - 1));
            else if (r < 8)
                it.lvl = 16'(origin - 2 + $urandom_range(0, 4));
            else
                it.lvl = 16'($urandom);
            it.idle_before = quiet ? 0 : idle_len();
            it.hold        = (k == hold_at);
            pending_items.push_back(it);
        end
    endtask

    task automatic write_count(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            tfi_pkg::REG_SMALL_CAP_ENTRIES: entry_count[tfi_pkg::TAB_SMALL_CAP] = val;
            tfi_pkg::REG_LARGE_CAP_ENTRIES: entry_count[tfi_pkg::TAB_LARGE_CAP] = val;
            tfi_pkg::REG_INDUCTOR_ENTRIES:  entry_count[tfi_pkg::TAB_INDUCTOR]  = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_counts(input logic [7:0] sc, input logic [7:0] lc, input logic [7:0] ind);
        write_count(tfi_pkg::REG_INDUCTOR_ENTRIES, ind);
        write_count(tfi_pkg::REG_SMALL_CAP_ENTRIES, sc);
        write_count(tfi_pkg::REG_LARGE_CAP_ENTRIES, lc);
    endtask

    // wait until every item went in and every lookup came back, then let loads settle
    task automatic drain();
        while (pending_items.size() != 0 || in_flight || factor_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // driver: presents one item at a time, holds it until the transfer
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (took_item)
            begin
                took_item = 1'b0;
                in_flight = 1'b0;
            end
            if (!in_flight)
            begin
                // a held item waits for all outstanding lookups to come back
                if (pending_items.size() == 0
                    || (pending_items[0].hold && factor_due.size() != 0))
                begin
                    start <= 1'b0;
                end
                else if (idle_count < pending_items[0].idle_before)
                begin
                    idle_count++;
                    start <= 1'b0;
                end
                else
                begin
                    next_item    = pending_items.pop_front();
                    idle_count   = 0;
                    mode         <= next_item.mode;
                    table_choice <= next_item.choice;
                    entry_index  <= next_item.slot;
                    entry_value  <= next_item.value;
                    level        <= next_item.lvl;
                    start        <= 1'b1;
                    in_flight    = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks results first, then records the item transfer of
    // the same edge, so the order of the two never matters
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        tfi_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (factor_due.size() == 0)
                begin
                    report_mismatch($sformatf("result factor %0d bad_table %0b with none expected",
                                              factor, bad_table));
                end
                else
                begin
                    want = factor_due.pop_front();
                    if (factor !== want.factor)
                        report_mismatch($sformatf("factor %0d, expected %0d",
                                                  factor, want.factor));
                    if (bad_table !== want.bad)
                        report_mismatch($sformatf("bad_table %0b, expected %0b",
                                                  bad_table, want.bad));
                end
            end
            if (start && !busy)
            begin
                took_item = 1'b1;
                if (mode == tfi_pkg::MODE_LOAD)
                begin
                    // a load to no table is dropped
                    if (table_choice != tfi_pkg::TAB_NONE)
                        factor_words[table_choice][entry_index] = entry_value;
                end
                else if (table_choice == tfi_pkg::TAB_NONE)
                begin
                    want.factor = 16'd0;
                    want.bad    = 1'b1;
                    factor_due.push_back(want);
                end
                else
                begin
                    want.factor = blend_factor(table_choice, level);
                    want.bad    = 1'b0;
                    factor_due.push_back(want);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int t = 0; t < 3; t++)
        begin
            entry_count[t] = tfi_pkg::ENTRIES_RESET;
            for (int e = 0; e < 128; e++)
                factor_words[t][e] = 16'd0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at reset counts of two: only entries 0 and 1 are read
        queue_item(tfi_pkg::MODE_LOOKUP, tfi_pkg::TAB_NONE,      7'd0,   16'd0,    16'd0,    0);
        queue_item(tfi_pkg::MODE_LOAD,   tfi_pkg::TAB_SMALL_CAP, 7'd0,   16'd0,    16'd0,    0);
        queue_item(tfi_pkg::MODE_LOAD,   tfi_pkg::TAB_SMALL_CAP, 7'd1,   16'hffff, 16'd0,    0);
        queue_item(tfi_pkg::MODE_LOAD,   tfi_pkg::TAB_LARGE_CAP, 7'd0,   16'hffff, 16'd0,    0);
        queue_item(tfi_pkg::MODE_LOAD,   tfi_pkg::TAB_LARGE_CAP, 7'd1,   16'd0,    16'd0,    0);
        queue_item(tfi_pkg::MODE_LOAD,   tfi_pkg::TAB_INDUCTOR,  7'd0,   16'd1234, 16'd0,    0);
        queue_item(tfi_pkg::MODE_LOAD,   tfi_pkg::TAB_INDUCTOR,  7'd1,   16'd4321, 16'd0,    0);
        // load to no table must leave every table alone
        queue_item(tfi_pkg::MODE_LOAD,   tfi_pkg::TAB_NONE,      7'd1,   16'hffff, 16'hffff, 0);
        queue_item(tfi_pkg::MODE_LOAD,   tfi_pkg::TAB_SMALL_CAP, 7'd127, 16'h5a5a, 16'd0,    0);
        // below the start, at it, inside the first step and far above the table
        queue_item(tfi_pkg::MODE_LOOKUP, tfi_pkg::TAB_SMALL_CAP, 7'd0,   16'd0,    16'd0,    0);
        queue_item(tfi_pkg::MODE_LOOKUP, tfi_pkg::TAB_SMALL_CAP, 7'd0,   16'd0,    16'd1000, 0);
        queue_item(tfi_pkg::MODE_LOOKUP, tfi_pkg::TAB_SMALL_CAP, 7'd0,   16'd0,    16'd1025, 1);
        queue_item(tfi_pkg::MODE_LOOKUP, tfi_pkg::TAB_SMALL_CAP, 7'd0,   16'd0,    16'd1049, 0);
        queue_item(tfi_pkg::MODE_LOOKUP, tfi_pkg::TAB_SMALL_CAP, 7'd127, 16'hffff, 16'hffff, 0);
        queue_item(tfi_pkg::MODE_LOOKUP, tfi_pkg::TAB_LARGE_CAP, 7'd0,   16'd0,    16'd300,  0);
        queue_item(tfi_pkg::MODE_LOOKUP, tfi_pkg::TAB_LARGE_CAP, 7'd0,   16'd0,    16'd312,  2);
        queue_item(tfi_pkg::MODE_LOOKUP, tfi_pkg::TAB_LARGE_CAP, 7'd0,   16'd0,    16'd299,  0);
        queue_item(tfi_pkg::MODE_LOOKUP, tfi_pkg::TAB_INDUCTOR,  7'd0,   16'd0,    16'd200,  0);
        queue_item(tfi_pkg::MODE_LOOKUP, tfi_pkg::TAB_INDUCTOR,  7'd0,   16'd0,    16'hffff, 0);
        queue_item(tfi_pkg::MODE_LOOKUP, tfi_pkg::TAB_NONE,      7'd127, 16'hffff, 16'hffff, 0);
        // lookup straight after a load of the entry it reads
        queue_item(tfi_pkg::MODE_LOAD,   tfi_pkg::TAB_INDUCTOR,  7'd1,   16'hffff, 16'd0,    0);
        queue_item(tfi_pkg::MODE_LOOKUP, tfi_pkg::TAB_INDUCTOR,  7'd0,   16'd0,    16'd210,  0);
        drain();

        // fill every entry of every table so any count can be read safely
        for (int t = 0; t < 3; t++)
            for (int e = 0; e < 128; e++)
                queue_item(tfi_pkg::MODE_LOAD, 2'(t), 7'(e),
                           ($urandom_range(0, 9) == 0) ? 16'hffff : 16'($urandom),
                           16'($urandom), idle_len());
        drain();

        set_counts(8'd128, 8'd128, 8'd128);
        queue_random(300, -1);
        drain();

        // counts below two and above the depth, with a pause for all results mid-phase
        set_counts(8'd0, 8'd1, 8'd255);
        queue_random(250, 120);
        drain();

        // write to no register: counts must stay as they are
        write_count(REG_NONE, 8'($urandom));
        set_counts(8'd129, 8'd64, 8'd127);
        queue_random(250, -1);
        drain();

        set_counts(8'($urandom_range(2, 128)), 8'($urandom_range(2, 128)),
                   8'($urandom_range(2, 128)));
        queue_random(250, -1);
        drain();

        set_counts(8'($urandom_range(2, 40)), 8'($urandom_range(2, 128)),
                   8'($urandom_range(2, 10)));
        queue_random(250, -1);
        drain();

        set_counts(8'd2, 8'd2, 8'd2);
        queue_random(250, -1);
        drain();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
